[sv/assert_macros.svh]
// Assertion macros shared by the stepper ramp RTL.
// Included by the modules that carry concurrent checks.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define SRP_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
    else $error("%m: implication failed");

// The consequent must hold in the cycle after the antecedent.
`define SRP_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
    else $error("%m: next-cycle implication failed");

// The condition must never be true.
`define SRP_ASSERT_NEVER(label, clk, rst_n, cond) \
  label: assert property (@(posedge clk) disable iff (!(rst_n)) !(cond)) \
    else $error("%m: forbidden condition seen");

`endif

[sv/srp_pkg.sv]
// Shared types and constants for the stepper step generator with smoothstep ramp.
// No dependencies; used by every module of the block.
package srp_pkg;

  localparam int DATA_W = 32;
  localparam int Q_BITS = 16;
  localparam int P_W = Q_BITS + 1;
  localparam int MUL_AW = 2 * Q_BITS + 1;
  localparam int MUL_BW = Q_BITS + 2;
  localparam int INTERVAL_FRAC_BITS = 8;
  localparam int CFG_IDX_W = 1;

  localparam logic [MUL_BW-1:0] SMOOTH_K = MUL_BW'(3 * (1 << Q_BITS));
  localparam logic [P_W-1:0] P_ONE = P_W'(1 << Q_BITS);

  localparam logic [2:0] MODE_TICK = 3'd0;
  localparam logic [2:0] MODE_RUN = 3'd1;
  localparam logic [2:0] MODE_MOVE = 3'd2;
  localparam logic [2:0] MODE_STOP = 3'd3;
  localparam logic [2:0] MODE_RETARGET = 3'd4;

  localparam logic [1:0] RUN_STOP = 2'd0;
  localparam logic [1:0] RUN_CONT = 2'd1;
  localparam logic [1:0] RUN_MOVE = 2'd2;

  localparam logic [CFG_IDX_W-1:0] CFG_RAMP_TICKS = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_INIT_INTERVAL = 1'd1;

  localparam logic [DATA_W-1:0] RST_RAMP_TICKS = 32'd1000000;
  localparam logic [DATA_W-1:0] RST_INIT_INTERVAL = 32'd1920000;
  localparam logic [DATA_W-1:0] RST_GOAL_INTERVAL = 32'd192000;

  // Status of a serial arithmetic unit.
  typedef struct packed {
    logic busy;
    logic done;
  } unit_stat_t;

endpackage

[sv/srp_mul.sv]
// Bit-serial shift-add multiplier, one multiplier bit per cycle.
// Depends on srp_pkg for default widths and the status struct.
module srp_mul #(
  parameter int AW = srp_pkg::MUL_AW,
  parameter int BW = srp_pkg::MUL_BW
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  start_i,
  input  logic [AW-1:0]         a_i,
  input  logic [BW-1:0]         b_i,
  output srp_pkg::unit_stat_t   stat_o,
  output logic [AW+BW-1:0]      prod_o
);

  localparam int PW = AW + BW;
  localparam int CW = $clog2(BW);

  logic [AW-1:0] a_q;
  logic [PW-1:0] prod_q;
  logic [CW-1:0] cnt_q;
  logic          busy_q;
  logic          done_q;
  logic [AW:0]   sum;

  // Add the multiplicand into the upper half when the low bit is set, then shift right.
  assign sum = {1'b0, prod_q[PW-1:BW]} + (prod_q[0] ? {1'b0, a_q} : '0);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
      end else if (busy_q) begin
        cnt_q <= cnt_q + 1'b1;
        if (cnt_q == CW'(BW - 1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      a_q    <= a_i;
      prod_q <= {{AW{1'b0}}, b_i};
    end else if (busy_q) begin
      prod_q <= {sum, prod_q[BW-1:1]};
    end
  end

  assign stat_o.busy = busy_q;
  assign stat_o.done = done_q;
  assign prod_o = prod_q;

endmodule

[sv/srp_div.sv]
// Restoring divider, one quotient bit per cycle, for a numerator not above the divisor.
// Gives floor(num * 2^(QW-1) / den). Depends on srp_pkg.
module srp_div #(
  parameter int W  = srp_pkg::DATA_W,
  parameter int QW = srp_pkg::P_W
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                start_i,
  input  logic [W-1:0]        num_i,
  input  logic [W-1:0]        den_i,
  output srp_pkg::unit_stat_t stat_o,
  output logic [QW-1:0]       quo_o
);

  localparam int CW = $clog2(QW);

  logic [W:0]    rem_q;
  logic [W-1:0]  den_q;
  logic [QW-1:0] quo_q;
  logic [CW-1:0] cnt_q;
  logic          busy_q;
  logic          done_q;
  logic          ge;
  logic [W:0]    diff;

  assign ge   = rem_q >= {1'b0, den_q};
  assign diff = rem_q - {1'b0, den_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
      end else if (busy_q) begin
        cnt_q <= cnt_q + 1'b1;
        if (cnt_q == CW'(QW - 1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  // The remainder stays below twice the divisor after each step, so one spare bit is enough.
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      rem_q <= {1'b0, num_i};
      den_q <= den_i;
      quo_q <= '0;
    end else if (busy_q) begin
      rem_q <= ge ? {diff[W-1:0], 1'b0} : {rem_q[W-1:0], 1'b0};
      quo_q <= {quo_q[QW-2:0], ge};
    end
  end

  assign stat_o.busy = busy_q;
  assign stat_o.done = done_q;
  assign quo_o = quo_q;

endmodule

[sv/stepper_step_generator_ramp_unit.sv]
// Stepper step-pulse generator with smoothstep speed ramp; uses srp_pkg, srp_div, srp_mul.
// A command or a tick while stopped goes from accept straight to the output state; a tick
// while moving runs a 17-bit serial divide, then three serial multiplies on one shared
// unit, then the step test. Next beat is taken the cycle after the result is registered.
// Reset (async, active low): stopped, forward, configuration at its defaults, no result.
module stepper_step_generator_ramp_unit #(
  parameter int INTERVAL_FRAC_BITS = srp_pkg::INTERVAL_FRAC_BITS
) (
  input  logic                                   clk_i,
  input  logic                                   rst_ni,
  input  logic                                   cfg_we_i,
  input  logic [srp_pkg::CFG_IDX_W-1:0]          cfg_index_i,
  input  logic [srp_pkg::DATA_W-1:0]             cfg_data_i,
  input  logic                                   in_valid_i,
  output logic                                   in_stall_o,
  input  logic [2:0]                             mode_i,
  input  logic                                   direction_forward_i,
  input  logic [srp_pkg::DATA_W-1:0]             target_interval_i,
  input  logic [srp_pkg::DATA_W-1:0]             step_count_i,
  output logic                                   out_valid_o,
  input  logic                                   out_stall_i,
  output logic                                   step_pulse_o,
  output logic                                   step_direction_o,
  output logic [1:0]                             motion_state_o,
  output logic                                   move_done_o,
  output logic [srp_pkg::DATA_W-1:0]             interval_now_o,
  output logic [srp_pkg::DATA_W-1:0]             steps_left_o,
  output logic [srp_pkg::DATA_W-1:0]             steps_total_o
);

  `include "assert_macros.svh"

  localparam int DW = srp_pkg::DATA_W;
  localparam int QB = srp_pkg::Q_BITS;
  localparam int PW = srp_pkg::P_W;
  localparam int AW = srp_pkg::MUL_AW;
  localparam int BW = srp_pkg::MUL_BW;
  localparam int SW = DW + INTERVAL_FRAC_BITS;

  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_LAUNCH = 3'd1;
  localparam logic [2:0] S_DIV    = 3'd2;
  localparam logic [2:0] S_MUL1   = 3'd3;
  localparam logic [2:0] S_MUL2   = 3'd4;
  localparam logic [2:0] S_MUL3   = 3'd5;
  localparam logic [2:0] S_STEP   = 3'd6;
  localparam logic [2:0] S_OUT    = 3'd7;

  logic [2:0]    state_q;
  logic [DW-1:0] ramp_ticks_q;
  logic [DW-1:0] init_int_q;
  logic [1:0]    run_q;
  logic          dir_q;
  logic [DW-1:0] since_q;
  logic [DW-1:0] elapsed_q;
  logic [DW-1:0] origin_q;
  logic [DW-1:0] goal_q;
  logic [DW-1:0] active_q;
  logic [DW-1:0] remain_q;
  logic [DW-1:0] tally_q;
  logic          pulse_q;
  logic          done_q;

  logic          out_valid_q;
  logic          out_pulse_q;
  logic          out_dir_q;
  logic [1:0]    out_run_q;
  logic          out_done_q;
  logic [DW-1:0] out_int_q;
  logic [DW-1:0] out_left_q;
  logic [DW-1:0] out_total_q;

  logic          in_fire;
  logic          out_fire;
  logic [DW-1:0] dur;
  logic [DW-1:0] el;
  logic          goal_up;
  logic [DW-1:0] span;
  logic [DW-1:0] delta;
  logic [DW-1:0] ramped;
  logic [DW-1:0] org_sel;
  logic [DW-1:0] tgt_sel;
  logic [DW-1:0] remain_dec;
  logic [SW-1:0] since_ext;
  logic          step_hit;
  logic          out_stopped;

  logic                div_start;
  srp_pkg::unit_stat_t div_stat;
  logic [PW-1:0]       div_quo;
  logic                mul_start;
  logic [AW-1:0]       mul_a;
  logic [BW-1:0]       mul_b;
  srp_pkg::unit_stat_t mul_stat;
  logic [AW+BW-1:0]    mul_prod;

  function automatic logic [DW-1:0] sat_inc(input logic [DW-1:0] v);
    sat_inc = (v == '1) ? v : v + 1'b1;
  endfunction

  assign in_stall_o = (state_q != S_IDLE);
  assign in_fire    = in_valid_i && (state_q == S_IDLE);
  assign out_fire   = (state_q == S_OUT) && (!out_valid_q || !out_stall_i);

  assign dur        = (ramp_ticks_q == '0) ? DW'(1) : ramp_ticks_q;
  assign el         = (elapsed_q < dur) ? elapsed_q : dur;
  assign goal_up    = goal_q >= origin_q;
  assign span       = goal_up ? goal_q - origin_q : origin_q - goal_q;
  // The eased fraction is truncated toward the origin on both ramp directions.
  assign delta      = mul_prod[QB +: DW];
  assign ramped     = goal_up ? origin_q + delta : origin_q - delta;
  assign org_sel    = (active_q != '0) ? active_q : init_int_q;
  assign tgt_sel    = (target_interval_i != '0) ? target_interval_i : DW'(1);
  assign remain_dec = (remain_q != '0) ? remain_q - 1'b1 : '0;
  assign since_ext  = SW'(since_q) << INTERVAL_FRAC_BITS;
  assign step_hit   = since_ext >= SW'(active_q);

  assign div_start = (state_q == S_LAUNCH);

  // Shared multiplier: p*p, then p*p*(3 - 2p), then the distance times the eased fraction.
  always_comb begin
    mul_start = 1'b0;
    mul_a     = '0;
    mul_b     = '0;
    case (state_q)
      S_DIV: begin
        mul_start = div_stat.done;
        mul_a     = AW'(div_quo);
        mul_b     = BW'(div_quo);
      end
      S_MUL1: begin
        mul_start = mul_stat.done;
        mul_a     = mul_prod[AW-1:0];
        mul_b     = srp_pkg::SMOOTH_K - {div_quo, 1'b0};
      end
      S_MUL2: begin
        mul_start = mul_stat.done;
        mul_a     = AW'(span);
        mul_b     = BW'(mul_prod[2*QB +: PW]);
      end
      default: begin
        mul_start = 1'b0;
      end
    endcase
  end

  srp_div #(
    .W  (DW),
    .QW (PW)
  ) u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (div_start),
    .num_i   (el),
    .den_i   (dur),
    .stat_o  (div_stat),
    .quo_o   (div_quo)
  );

  srp_mul #(
    .AW (AW),
    .BW (BW)
  ) u_mul (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (mul_start),
    .a_i     (mul_a),
    .b_i     (mul_b),
    .stat_o  (mul_stat),
    .prod_o  (mul_prod)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= S_IDLE;
      ramp_ticks_q <= srp_pkg::RST_RAMP_TICKS;
      init_int_q   <= srp_pkg::RST_INIT_INTERVAL;
      run_q        <= srp_pkg::RUN_STOP;
      dir_q        <= 1'b1;
      since_q      <= '0;
      elapsed_q    <= '0;
      origin_q     <= '0;
      goal_q       <= srp_pkg::RST_GOAL_INTERVAL;
      active_q     <= srp_pkg::RST_INIT_INTERVAL;
      remain_q     <= '0;
      tally_q      <= '0;
      pulse_q      <= 1'b0;
      done_q       <= 1'b0;
    end else begin
      case (state_q)
        S_IDLE: begin
          if (in_fire) begin
            pulse_q <= 1'b0;
            done_q  <= 1'b0;
            state_q <= S_OUT;
            case (mode_i)
              srp_pkg::MODE_TICK: begin
                since_q   <= sat_inc(since_q);
                elapsed_q <= sat_inc(elapsed_q);
                if (run_q != srp_pkg::RUN_STOP) begin
                  state_q <= S_LAUNCH;
                end
              end
              srp_pkg::MODE_RUN: begin
                dir_q     <= direction_forward_i;
                elapsed_q <= '0;
                origin_q  <= org_sel;
                goal_q    <= tgt_sel;
                since_q   <= '0;
                run_q     <= srp_pkg::RUN_CONT;
              end
              srp_pkg::MODE_MOVE: begin
                dir_q     <= direction_forward_i;
                elapsed_q <= '0;
                origin_q  <= org_sel;
                goal_q    <= tgt_sel;
                remain_q  <= step_count_i;
                since_q   <= '0;
                run_q     <= (step_count_i != '0) ? srp_pkg::RUN_MOVE : srp_pkg::RUN_STOP;
              end
              srp_pkg::MODE_STOP: begin
                run_q    <= srp_pkg::RUN_STOP;
                remain_q <= '0;
              end
              srp_pkg::MODE_RETARGET: begin
                elapsed_q <= '0;
                origin_q  <= org_sel;
                goal_q    <= tgt_sel;
              end
              default: begin
                run_q <= run_q;
              end
            endcase
          end
        end
        S_LAUNCH: begin
          state_q <= S_DIV;
        end
        S_DIV: begin
          if (div_stat.done) begin
            state_q <= S_MUL1;
          end
        end
        S_MUL1: begin
          if (mul_stat.done) begin
            state_q <= S_MUL2;
          end
        end
        S_MUL2: begin
          if (mul_stat.done) begin
            state_q <= S_MUL3;
          end
        end
        S_MUL3: begin
          if (mul_stat.done) begin
            active_q <= ramped;
            state_q  <= S_STEP;
          end
        end
        S_STEP: begin
          if (step_hit) begin
            pulse_q <= 1'b1;
            since_q <= '0;
            tally_q <= tally_q + 1'b1;
            if (run_q == srp_pkg::RUN_MOVE) begin
              remain_q <= remain_dec;
              if (remain_dec == '0) begin
                run_q  <= srp_pkg::RUN_STOP;
                done_q <= 1'b1;
              end
            end
          end
          state_q <= S_OUT;
        end
        S_OUT: begin
          if (out_fire) begin
            state_q <= S_IDLE;
          end
        end
        default: begin
          state_q <= S_IDLE;
        end
      endcase

      // The user must write configuration only while idle; the block itself does not enforce it.
      if (cfg_we_i) begin
        if (cfg_index_i == srp_pkg::CFG_RAMP_TICKS) begin
          ramp_ticks_q <= cfg_data_i;
        end else if (cfg_index_i == srp_pkg::CFG_INIT_INTERVAL) begin
          init_int_q <= cfg_data_i;
          if (run_q == srp_pkg::RUN_STOP) begin
            active_q <= cfg_data_i;
          end
        end
      end
    end
  end

  // Output register: holds a finished beat while the next item is taken.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_fire) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_fire) begin
      out_pulse_q <= pulse_q;
      out_dir_q   <= dir_q;
      out_run_q   <= run_q;
      out_done_q  <= done_q;
      out_int_q   <= active_q;
      out_left_q  <= remain_q;
      out_total_q <= tally_q;
    end
  end

  assign out_valid_o      = out_valid_q;
  assign step_pulse_o     = out_pulse_q;
  assign step_direction_o = out_dir_q;
  assign motion_state_o   = out_run_q;
  assign move_done_o      = out_done_q;
  assign interval_now_o   = out_int_q;
  assign steps_left_o     = out_left_q;
  assign steps_total_o    = out_total_q;

  assign out_stopped = (motion_state_o == srp_pkg::RUN_STOP) && (steps_left_o == '0);

  `SRP_ASSERT_IMPL(a_done_means_stopped, clk_i, rst_ni, out_valid_o && move_done_o, out_stopped)
  `SRP_ASSERT_IMPL(a_progress_range, clk_i, rst_ni, div_stat.done, div_quo <= srp_pkg::P_ONE)
  `SRP_ASSERT_IMPL(a_mul_start_idle, clk_i, rst_ni, mul_start, !mul_stat.busy)
  `SRP_ASSERT_IMPL(a_step_while_moving, clk_i, rst_ni, state_q == S_STEP, run_q != srp_pkg::RUN_STOP)

endmodule
